>>> rtl/kcla_pkg.sv
// Shared types and constants for the keypad code lock alarm.
// Request structs, mode and event codes, key codes, register reset values.
// No dependencies.
package kcla_pkg;

    localparam int CODE_LEN_DEF = 4;

    localparam logic [31:0] PASSCODE_RST = 32'h3132_3334;
    localparam logic [7:0]  TRIGGER_RST  = 8'd4;
    localparam logic [7:0]  TIMEOUT_RST  = 8'd10;

    localparam logic [1:0] CFG_PASSCODE = 2'd0;
    localparam logic [1:0] CFG_TRIGGER  = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT  = 2'd2;

    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_SENSOR = 2'd1;
    localparam logic [1:0] KIND_KEY    = 2'd2;

    localparam logic [7:0] KEY_STAR  = 8'h2A;
    localparam logic [7:0] KEY_HASH  = 8'h23;
    localparam logic [7:0] KEY_REARM = 8'h41;

    localparam logic [1:0] MODE_CODE_ARMED = 2'd0;
    localparam logic [1:0] MODE_CODE_ENTRY = 2'd1;
    localparam logic [1:0] MODE_CODE_OPEN  = 2'd2;

    typedef enum logic [2:0] {
        MODE_ARMED = 3'b001,
        MODE_ENTRY = 3'b010,
        MODE_OPEN  = 3'b100
    } t_mode;

    typedef enum logic [3:0] {
        EV_NONE      = 4'd0,
        EV_TRIGGERED = 4'd1,
        EV_STORED    = 4'd2,
        EV_BACKSPACE = 4'd3,
        EV_SHORT     = 4'd4,
        EV_OVERFLOW  = 4'd5,
        EV_WRONG     = 4'd6,
        EV_UNLOCKED  = 4'd7,
        EV_TIMEOUT   = 4'd8,
        EV_REARMED   = 4'd9
    } t_event;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] sensor_value;
        logic [7:0] key_code;
    } t_in_item;

    typedef struct packed {
        logic [1:0] mode;
        logic       buzzer_on;
        logic       unlock_light;
        logic       timer_light;
        logic       timer_running;
        logic [2:0] entered_count;
        logic [7:0] elapsed;
        logic [3:0] event_res;
    } t_out_item;

    typedef struct packed {
        logic [31:0] passcode;
        logic [7:0]  trigger_value;
        logic [7:0]  timeout_seconds;
    } t_cfg;

endpackage

>>> rtl/kcla_cfg.sv
// Configuration registers of the keypad code lock alarm.
// Depends on kcla_pkg.
module kcla_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    output kcla_pkg::t_cfg      o_cfg
);
    import kcla_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.passcode        <= PASSCODE_RST;
            r_cfg.trigger_value   <= TRIGGER_RST;
            r_cfg.timeout_seconds <= TIMEOUT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PASSCODE: r_cfg.passcode        <= i_cfg_data;
                CFG_TRIGGER:  r_cfg.trigger_value   <= i_cfg_data[7:0];
                CFG_TIMEOUT:  r_cfg.timeout_seconds <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

endmodule

>>> rtl/kcla_core.sv
// Lock state and single-pass update logic for one request.
// Depends on kcla_pkg.
module kcla_core #(
    parameter int CODE_LEN = kcla_pkg::CODE_LEN_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  kcla_pkg::t_in_item  i_item,
    input  kcla_pkg::t_cfg      i_cfg,
    output kcla_pkg::t_out_item o_result
);
    import kcla_pkg::*;

    localparam int KCW = $clog2(CODE_LEN + 1);
    localparam logic [KCW-1:0] FULL = KCW'(CODE_LEN);

    t_mode          r_mode, n_mode;
    logic [7:0]     r_keys [CODE_LEN];
    logic [7:0]     n_keys [CODE_LEN];
    logic [KCW-1:0] r_count, n_count;
    logic [7:0]     r_sec, n_sec;
    logic           r_counting, n_counting;
    logic           r_alarm, n_alarm;
    logic           r_blink, n_blink;
    logic           r_open, n_open;
    t_event         ev;
    logic           match;
    logic [3:0]     count_ext;

    always_comb begin
        int pos;
        match = 1'b1;
        for (int i = 0; i < CODE_LEN; i++) begin
            pos = CODE_LEN - 1 - i;
            if (pos < 4) begin
                if (r_keys[i] != i_cfg.passcode[8*pos +: 8]) match = 1'b0;
            end else begin
                if (r_keys[i] != 8'd0) match = 1'b0;
            end
        end
    end

    always_comb begin
        n_mode     = r_mode;
        n_keys     = r_keys;
        n_count    = r_count;
        n_sec      = r_sec;
        n_counting = r_counting;
        n_alarm    = r_alarm;
        n_blink    = r_blink;
        n_open     = r_open;
        ev         = EV_NONE;
        if (i_step) begin
            case (i_item.kind)
                KIND_TICK: begin
                    if (r_counting) begin
                        n_blink = !r_blink;
                        if (r_sec != 8'hFF) n_sec = r_sec + 8'd1;
                        if (n_sec >= i_cfg.timeout_seconds) begin
                            n_counting = 1'b0;
                            n_alarm    = 1'b1;
                            ev         = EV_TIMEOUT;
                        end
                    end
                end
                KIND_SENSOR: begin
                    if (r_mode == MODE_ARMED
                        && i_item.sensor_value == i_cfg.trigger_value) begin
                        n_mode     = MODE_ENTRY;
                        n_counting = 1'b1;
                        n_blink    = 1'b1;
                        ev         = EV_TRIGGERED;
                    end
                end
                KIND_KEY: begin
                    if (r_mode == MODE_ENTRY) begin
                        if (i_item.key_code == KEY_STAR) begin
                            if (r_count != '0) begin
                                n_count = r_count - 1'b1;
                                ev      = EV_BACKSPACE;
                            end
                        end else if (i_item.key_code == KEY_HASH) begin
                            if (r_count < FULL) begin
                                n_count = '0;
                                ev      = EV_SHORT;
                            end else if (match) begin
                                n_mode     = MODE_OPEN;
                                n_counting = 1'b0;
                                for (int i = 0; i < CODE_LEN; i++) n_keys[i] = 8'd0;
                                n_count    = '0;
                                n_open     = 1'b1;
                                n_blink    = 1'b0;
                                n_alarm    = 1'b0;
                                ev         = EV_UNLOCKED;
                            end else begin
                                n_count    = '0;
                                n_counting = 1'b0;
                                n_alarm    = 1'b1;
                                ev         = EV_WRONG;
                            end
                        end else if (r_count >= FULL) begin
                            n_count = '0;
                            ev      = EV_OVERFLOW;
                        end else begin
                            for (int i = 0; i < CODE_LEN; i++) begin
                                if (KCW'(i) == r_count) n_keys[i] = i_item.key_code;
                            end
                            n_count = r_count + 1'b1;
                            ev      = EV_STORED;
                        end
                    end else if (r_mode == MODE_OPEN && i_item.key_code == KEY_REARM) begin
                        n_mode = MODE_ARMED;
                        n_open = 1'b0;
                        n_sec  = 8'd0;
                        ev     = EV_REARMED;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_ARMED;
            for (int i = 0; i < CODE_LEN; i++) r_keys[i] <= 8'd0;
            r_count    <= '0;
            r_sec      <= 8'd0;
            r_counting <= 1'b0;
            r_alarm    <= 1'b0;
            r_blink    <= 1'b0;
            r_open     <= 1'b0;
        end else begin
            r_mode     <= n_mode;
            r_keys     <= n_keys;
            r_count    <= n_count;
            r_sec      <= n_sec;
            r_counting <= n_counting;
            r_alarm    <= n_alarm;
            r_blink    <= n_blink;
            r_open     <= n_open;
        end
    end

    // entered_count is reported in three bits
    assign count_ext = 4'(n_count);

    always_comb begin
        case (n_mode)
            MODE_ARMED: o_result.mode = MODE_CODE_ARMED;
            MODE_ENTRY: o_result.mode = MODE_CODE_ENTRY;
            MODE_OPEN:  o_result.mode = MODE_CODE_OPEN;
            default:    o_result.mode = MODE_CODE_ARMED;
        endcase
        o_result.buzzer_on     = n_alarm;
        o_result.unlock_light  = n_open;
        o_result.timer_light   = n_blink;
        o_result.timer_running = n_counting;
        o_result.entered_count = count_ext[2:0];
        o_result.elapsed       = n_sec;
        o_result.event_res     = ev;
    end

    a_count_only_in_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_counting |-> r_mode == MODE_ENTRY)
        else $error("seconds counter running outside entry mode");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("key count above code length");

    a_light_tracks_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open == (r_mode == MODE_OPEN))
        else $error("unlock light out of step with mode");

    a_alarm_stops_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_alarm |-> !r_counting)
        else $error("timer running with alarm latched");

endmodule

>>> rtl/keypad_code_lock_alarm.sv
// Top level of the keypad code lock alarm: input register, core, result register.
// Depends on kcla_pkg, kcla_cfg and kcla_core.
//
// Each request (tick, sensor report or key press) yields exactly one result
// with the lock status and an event code. One request is taken per clock while
// the result side does not stall; a result is presented after its request has
// passed the input register and the state update that loads the result register.
// Stall on the result side propagates back to the input stall combinationally.
// Configuration writes are always ready and take effect on the next request.
module keypad_code_lock_alarm #(
    parameter int CODE_LEN = kcla_pkg::CODE_LEN_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  kcla_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output kcla_pkg::t_out_item o_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    import kcla_pkg::*;

    t_cfg      cfg;
    t_in_item  r_in;
    logic      r_in_valid;
    t_out_item r_out;
    logic      r_out_valid;
    t_out_item result;
    logic      adv;

    assign adv         = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_in_valid && !adv;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    kcla_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    kcla_core #(
        .CODE_LEN (CODE_LEN)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (r_in_valid && adv),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in;
        end
        if (adv && r_in_valid) begin
            r_out <= result;
        end
    end

endmodule

>>> sim/kcla_lock_checker.sv
// Result checker for the keypad code lock alarm: watches the request, result and
// register write channels, predicts each lock status and compares it in order.
// Depends on kcla_pkg.
module kcla_lock_checker #(
    parameter int CODE_LEN = kcla_pkg::CODE_LEN_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  kcla_pkg::t_in_item  i_in,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  kcla_pkg::t_out_item i_out,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    output int                  o_pending,
    output int                  o_failures
);
    timeunit 1ns;
    timeprecision 1ps;
    import kcla_pkg::*;

    logic [31:0] code_reg;
    logic [7:0]  trig_reg;
    logic [7:0]  limit_reg;

    logic [1:0]  lock_mode;
    logic [7:0]  held_keys [CODE_LEN];
    logic [3:0]  n_keys;
    logic [7:0]  secs;
    logic        counting;
    logic        alarm;
    logic        blink;
    logic        lit;

    t_out_item   status_q[$];
    int          fails = 0;

    function automatic logic [7:0] secret_byte(int i);
        logic [31:0] sh;
        sh = code_reg >> (8 * (CODE_LEN - 1 - i));
        return sh[7:0];
    endfunction

    function automatic t_event press_key(logic [7:0] key);
        logic hit;
        hit = 1'b1;
        if (key == KEY_STAR) begin
            if (n_keys == 4'd0)
                return EV_NONE;
            n_keys = n_keys - 4'd1;
            return EV_BACKSPACE;
        end
        if (key == KEY_HASH) begin
            if (n_keys < CODE_LEN) begin
                n_keys = '0;
                return EV_SHORT;
            end
            for (int i = 0; i < CODE_LEN; i++)
                if (held_keys[i] != secret_byte(i))
                    hit = 1'b0;
            n_keys = '0;
            if (hit) begin
                lock_mode = MODE_CODE_OPEN;
                counting = 1'b0;
                foreach (held_keys[j])
                    held_keys[j] = 8'h00;
                lit = 1'b1;
                blink = 1'b0;
                alarm = 1'b0;
                return EV_UNLOCKED;
            end
            counting = 1'b0;
            alarm = 1'b1;
            return EV_WRONG;
        end
        if (n_keys >= CODE_LEN) begin
            n_keys = '0;
            return EV_OVERFLOW;
        end
        held_keys[n_keys] = key;
        n_keys = n_keys + 4'd1;
        return EV_STORED;
    endfunction

    function automatic t_out_item lock_step(t_in_item req);
        t_out_item res;
        t_event    ev;
        ev = EV_NONE;
        case (req.kind)
            KIND_TICK: begin
                if (counting) begin
                    blink = !blink;
                    if (secs != 8'hFF)
                        secs = secs + 8'd1;
                    if (secs >= limit_reg) begin
                        counting = 1'b0;
                        alarm = 1'b1;
                        ev = EV_TIMEOUT;
                    end
                end
            end
            KIND_SENSOR: begin
                if (lock_mode == MODE_CODE_ARMED && req.sensor_value == trig_reg) begin
                    lock_mode = MODE_CODE_ENTRY;
                    counting = 1'b1;
                    blink = 1'b1;
                    ev = EV_TRIGGERED;
                end
            end
            KIND_KEY: begin
                if (lock_mode == MODE_CODE_ENTRY) begin
                    ev = press_key(req.key_code);
                end else if (lock_mode == MODE_CODE_OPEN && req.key_code == KEY_REARM) begin
                    lock_mode = MODE_CODE_ARMED;
                    lit = 1'b0;
                    secs = 8'h00;
                    ev = EV_REARMED;
                end
            end
            default: ;
        endcase
        res.mode          = lock_mode;
        res.buzzer_on     = alarm;
        res.unlock_light  = lit;
        res.timer_light   = blink;
        res.timer_running = counting;
        res.entered_count = n_keys[2:0];
        res.elapsed       = secs;
        res.event_res     = ev;
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            code_reg  = PASSCODE_RST;
            trig_reg  = TRIGGER_RST;
            limit_reg = TIMEOUT_RST;
            lock_mode = MODE_CODE_ARMED;
            foreach (held_keys[j])
                held_keys[j] = 8'h00;
            n_keys   = '0;
            secs     = 8'h00;
            counting = 1'b0;
            alarm    = 1'b0;
            blink    = 1'b0;
            lit      = 1'b0;
            status_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (status_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%t lock status with no request pending: %h", $realtime, i_out);
                end else begin
                    want = status_q.pop_front();
                    if (want.mode !== i_out.mode || want.buzzer_on !== i_out.buzzer_on ||
                        want.unlock_light !== i_out.unlock_light ||
                        want.timer_light !== i_out.timer_light ||
                        want.timer_running !== i_out.timer_running ||
                        want.entered_count !== i_out.entered_count ||
                        want.elapsed !== i_out.elapsed || want.event_res !== i_out.event_res) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("%t lock status mismatch", $realtime);
                            $display("  exp mode=%0d buzz=%b open=%b blink=%b run=%b keys=%0d secs=%0d ev=%0d",
                                     want.mode, want.buzzer_on, want.unlock_light,
                                     want.timer_light, want.timer_running,
                                     want.entered_count, want.elapsed, want.event_res);
                            $display("  got mode=%0d buzz=%b open=%b blink=%b run=%b keys=%0d secs=%0d ev=%0d",
                                     i_out.mode, i_out.buzzer_on, i_out.unlock_light,
                                     i_out.timer_light, i_out.timer_running,
                                     i_out.entered_count, i_out.elapsed, i_out.event_res);
                        end
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PASSCODE: code_reg  = i_cfg_data;
                    CFG_TRIGGER:  trig_reg  = i_cfg_data[7:0];
                    CFG_TIMEOUT:  limit_reg = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                status_q.push_back(lock_step(i_in));
        end
        o_pending  <= status_q.size();
        o_failures <= fails;
    end

endmodule

>>> sim/tb_keypad_code_lock_alarm.sv
// Testbench top for the keypad code lock alarm: clock, reset, request and register
// stimulus with random idling; results are judged by kcla_lock_checker.
// Depends on kcla_pkg, kcla_lock_checker and keypad_code_lock_alarm.
module tb_keypad_code_lock_alarm;
    timeunit 1ns;
    timeprecision 1ps;
    import kcla_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_in_item    in_req = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_item   out_res;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_PASSCODE;
    logic [31:0] cfg_data = '0;
    int          pending;
    int          failures;

    logic [31:0] cur_code;
    logic [7:0]  cur_trigger;
    bit          tx_idle_on = 1'b0;
    bit          rx_idle_on = 1'b0;
    int          sent = 0;

    keypad_code_lock_alarm dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_res),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    kcla_lock_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in        (in_req),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out       (out_res),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_pending   (pending),
        .o_failures  (failures)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic t_in_item mk_req(logic [1:0] kind, logic [7:0] sensor, logic [7:0] key);
        t_in_item r;
        r.kind = kind;
        r.sensor_value = sensor;
        r.key_code = key;
        return r;
    endfunction

    function automatic t_in_item key_req(logic [7:0] key);
        return mk_req(KIND_KEY, 8'($urandom), key);
    endfunction

    function automatic t_in_item tick_req();
        return mk_req(KIND_TICK, 8'($urandom), 8'($urandom));
    endfunction

    task automatic send(input t_in_item req);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
    endtask

    task automatic drain_requests();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic put_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic write_config(input logic [31:0] code, input logic [7:0] trig,
                                input logic [7:0] secs);
        logic [31:0] noise;
        noise = $urandom;
        put_reg(CFG_PASSCODE, code);
        put_reg(CFG_TRIGGER, {noise[31:8], trig});
        noise = $urandom;
        put_reg(CFG_TIMEOUT, {noise[31:8], secs});
        cfg_valid <= 1'b0;
        cur_code = code;
        cur_trigger = trig;
    endtask

    task automatic send_ticks(input int max_n);
        repeat ($urandom_range(0, max_n))
            send(tick_req());
    endtask

    // trigger, code entry with typos, hash, rearm
    task automatic run_episode();
        int v;
        int n_keys;
        int wrong_pos;
        logic [7:0] k;
        v = $urandom_range(0, 9);
        n_keys = (v == 8) ? $urandom_range(0, 3) : 4;
        wrong_pos = (v == 6 || v == 7) ? $urandom_range(0, 3) : -1;
        send(mk_req(KIND_SENSOR, cur_trigger, 8'($urandom)));
        send_ticks(2);
        for (int i = 0; i < n_keys; i++) begin
            k = cur_code[8 * (3 - i) +: 8];
            if (i == wrong_pos)
                k = 8'($urandom);
            if ($urandom_range(0, 5) == 0) begin
                send(key_req(8'($urandom_range(8'h30, 8'h39))));
                send(key_req(KEY_STAR));
            end
            send(key_req(k));
            if ($urandom_range(0, 4) == 0)
                send_ticks(2);
        end
        if (v == 9)
            send(key_req(8'($urandom)));
        send(key_req(KEY_HASH));
        send_ticks(2);
        send(key_req(($urandom_range(0, 4) != 0) ? KEY_REARM : 8'($urandom)));
    endtask

    task automatic run_random(input int n);
        int start;
        start = sent;
        while (sent - start < n) begin
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 3))
                    send(mk_req(2'($urandom), 8'($urandom), 8'($urandom)));
            end else begin
                run_episode();
            end
        end
    endtask

    initial begin : stimulus
        logic [31:0] code;
        logic [7:0]  trig;
        logic [7:0]  secs;
        t_in_item    plan[$];
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        cur_code = PASSCODE_RST;
        cur_trigger = TRIGGER_RST;

        plan.push_back(tick_req());
        plan.push_back(mk_req(2'b11, 8'hFF, 8'hFF));
        plan.push_back(key_req("1"));
        plan.push_back(mk_req(KIND_SENSOR, 8'hFF, 8'h00));
        plan.push_back(mk_req(KIND_SENSOR, TRIGGER_RST, 8'h00));
        plan.push_back(key_req(KEY_STAR));
        plan.push_back(key_req(KEY_HASH));
        plan.push_back(key_req("1"));
        plan.push_back(key_req(KEY_STAR));
        plan.push_back(key_req("1"));
        plan.push_back(key_req("2"));
        plan.push_back(key_req("3"));
        plan.push_back(key_req("4"));
        plan.push_back(key_req("5"));
        plan.push_back(key_req(8'h00));
        plan.push_back(key_req(8'hFF));
        plan.push_back(key_req("3"));
        plan.push_back(key_req("4"));
        plan.push_back(key_req(KEY_HASH));
        plan.push_back(key_req("1"));
        plan.push_back(key_req("2"));
        plan.push_back(key_req("3"));
        plan.push_back(key_req("4"));
        plan.push_back(key_req(KEY_HASH));
        plan.push_back(key_req(KEY_REARM));
        foreach (plan[i])
            send(plan[i]);
        drain_requests();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin code = $urandom; trig = 8'($urandom); secs = 8'd1; end
                1: begin code = 32'h0; trig = 8'h00; secs = 8'd0; end
                2: begin code = 32'hFFFF_FFFF; trig = 8'hFF; secs = 8'hFF; end
                default: begin
                    code = $urandom;
                    trig = 8'($urandom);
                    secs = 8'($urandom_range(3, 40));
                end
            endcase
            write_config(code, trig, secs);
            tx_idle_on = (phase % 3 != 1) && (phase != 7);
            rx_idle_on = (phase % 3 != 2) && (phase != 7);
            if (phase == 2) begin
                // force armed, then run the seconds counter up to its ceiling
                send(key_req(KEY_HASH));
                for (int i = 0; i < 4; i++)
                    send(key_req(cur_code[8 * (3 - i) +: 8]));
                send(key_req(KEY_HASH));
                send(key_req(KEY_REARM));
                send(mk_req(KIND_SENSOR, cur_trigger, 8'h00));
                repeat (258)
                    send(tick_req());
            end
            run_random(60);
            drain_requests();
        end
        repeat (8) @(posedge clk);
        if (failures == 0)
            $display("tb_keypad_code_lock_alarm: done, clean");
        else
            $display("tb_keypad_code_lock_alarm: done, errors");
        $finish;
    end

    initial begin : result_stall
        forever begin
            @(posedge clk);
            if (rx_idle_on && $urandom_range(0, 4) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("tb_keypad_code_lock_alarm: done, errors");
        $finish;
    end

endmodule
